// ----- sv/vntp_pkg.sv -----
// shared types and constants for the version name token parser
package vntp_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int OFFSET_BITS = 16;
  localparam int ACCUM_BITS = 32;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_LETTERS = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EXP_LETTER = 3'd1;
  localparam logic [2:0] ST_EXP_NUMBER = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_ZERO_SEG = 3'd4;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] LETTER_BIAS = 8'h60;

  localparam logic [31:0] BRANCH_RADIX = 32'd26;
  localparam logic [35:0] DECIMAL_RADIX = 36'd10;

  typedef struct packed {
    logic [7:0] character;
    logic       has_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic                   segment_valid;
    logic                   branch_present;
    logic [ACCUM_BITS-1:0]  branch_ordinal;
    logic [ACCUM_BITS-1:0]  segment_number;
    logic                   done_res;
    logic [2:0]             status;
    logic [OFFSET_BITS-1:0] error_offset;
  } out_item_t;

  typedef struct packed {
    logic      hit;
    out_item_t item;
  } parse_res_t;

endpackage

// ----- sv/vntp_parser.sv -----
// parse state registers and the per-character next-state and result logic
module vntp_parser
  import vntp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  in_item_t   item,
  output parse_res_t res
);

  logic [1:0]               phase, phase_next;
  logic [ACCUM_BITS-1:0]    baccum, baccum_next;
  logic                     bseen, bseen_next;
  logic [ACCUM_BITS-1:0]    naccum, naccum_next;
  logic                     segs, segs_next;
  logic [POSITION_BITS-1:0] cpos, cpos_next;
  logic [2:0]               fcode, fcode_next;
  logic [POSITION_BITS-1:0] fpos, fpos_next;

  logic                     is_upper, is_lower, is_digit;
  logic [7:0]               lc;
  logic [ACCUM_BITS-1:0]    letter_val;
  logic [ACCUM_BITS-1:0]    b_mul;
  logic [35:0]              n_wide;
  logic                     seg_emit;
  logic                     fin_seg;
  logic [2:0]               fin_st;
  logic [POSITION_BITS-1:0] fin_off;
  logic                     root;
  logic [OFFSET_BITS-1:0]   off_sat;

  assign is_upper = (item.character >= CHAR_UPPER_A) && (item.character <= CHAR_UPPER_Z);
  assign is_lower = (item.character >= CHAR_LOWER_A) && (item.character <= CHAR_LOWER_Z);
  assign is_digit = (item.character >= CHAR_ZERO) && (item.character <= CHAR_NINE);
  assign lc = item.character | CASE_BIT;
  assign letter_val = ACCUM_BITS'(lc - LETTER_BIAS);
  assign b_mul = baccum * BRANCH_RADIX;
  assign n_wide = {4'b0, naccum} * DECIMAL_RADIX + 36'(item.character - CHAR_ZERO);

  always_comb begin
    phase_next = phase;
    baccum_next = baccum;
    bseen_next = bseen;
    naccum_next = naccum;
    segs_next = segs;
    cpos_next = cpos;
    fcode_next = fcode;
    fpos_next = fpos;
    seg_emit = 1'b0;
    fin_seg = 1'b0;
    fin_st = ST_OK;
    fin_off = '0;
    root = 1'b0;

    if (item.has_char && fcode == ST_OK) begin
      if (is_upper || is_lower) begin
        if (phase == PH_LETTERS) begin
          baccum_next = b_mul + letter_val;
        end else if (phase == PH_DIGITS && naccum == '0) begin
          fcode_next = ST_ZERO_SEG;
          fpos_next = '0;
        end else begin
          if (phase == PH_DIGITS) begin
            seg_emit = 1'b1;
            segs_next = 1'b1;
          end
          phase_next = PH_LETTERS;
          bseen_next = 1'b1;
          baccum_next = letter_val;
          naccum_next = '0;
        end
      end else if (is_digit) begin
        if (|n_wide[35:32]) begin
          fcode_next = ST_TOO_LARGE;
          fpos_next = '0;
        end else begin
          naccum_next = n_wide[31:0];
          phase_next = PH_DIGITS;
        end
      end else if (phase == PH_DIGITS) begin
        if (naccum == '0) begin
          fcode_next = ST_ZERO_SEG;
          fpos_next = '0;
        end else begin
          fcode_next = ST_EXP_LETTER;
          fpos_next = cpos;
        end
      end else begin
        fcode_next = ST_EXP_NUMBER;
        fpos_next = cpos;
      end
    end

    if (item.has_char && cpos != '1) begin
      cpos_next = cpos + POSITION_BITS'(1);
    end

    if (item.end_of_text) begin
      fin_st = fcode_next;
      fin_off = fpos_next;
      if (fcode_next == ST_OK) begin
        fin_off = '0;
        if (phase_next == PH_LETTERS) begin
          fin_st = ST_EXP_NUMBER;
          fin_off = cpos_next;
        end else if (phase_next == PH_DIGITS) begin
          root = !bseen_next && !segs_next && naccum_next == '0
                 && cpos_next == POSITION_BITS'(1);
          if (!root) begin
            if (naccum_next == '0) begin
              fin_st = ST_ZERO_SEG;
            end else begin
              fin_seg = 1'b1;
            end
          end
        end
      end
    end
  end

  if (POSITION_BITS > OFFSET_BITS) begin : g_sat
    assign off_sat = (|fin_off[POSITION_BITS-1:OFFSET_BITS]) ? '1 : fin_off[OFFSET_BITS-1:0];
  end else begin : g_ext
    assign off_sat = OFFSET_BITS'(fin_off);
  end

  always_comb begin
    res = '0;
    if (item.end_of_text) begin
      res.hit = 1'b1;
      res.item.segment_valid = fin_seg;
      res.item.branch_present = fin_seg && bseen_next;
      res.item.branch_ordinal = (fin_seg && bseen_next) ? baccum_next : '0;
      res.item.segment_number = fin_seg ? naccum_next : '0;
      res.item.done_res = 1'b1;
      res.item.status = fin_st;
      res.item.error_offset = off_sat;
    end else if (seg_emit) begin
      res.hit = 1'b1;
      res.item.segment_valid = 1'b1;
      res.item.branch_present = bseen;
      res.item.branch_ordinal = bseen ? baccum : '0;
      res.item.segment_number = naccum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      baccum <= '0;
      bseen <= 1'b0;
      naccum <= '0;
      segs <= 1'b0;
      cpos <= '0;
      fcode <= ST_OK;
      fpos <= '0;
    end else if (en) begin
      if (item.end_of_text) begin
        phase <= PH_START;
        baccum <= '0;
        bseen <= 1'b0;
        naccum <= '0;
        segs <= 1'b0;
        cpos <= '0;
        fcode <= ST_OK;
        fpos <= '0;
      end else begin
        phase <= phase_next;
        baccum <= baccum_next;
        bseen <= bseen_next;
        naccum <= naccum_next;
        segs <= segs_next;
        cpos <= cpos_next;
        fcode <= fcode_next;
        fpos <= fpos_next;
      end
    end
  end

endmodule

// ----- sv/version_name_token_parser_top.sv -----
// Version name token parser: takes one character item per cycle while the
// output is not stalled, and returns completed segments and an end-of-text
// result with status. A character is registered on accept and is parsed
// once the output register is free, when its result (if any) is loaded into
// the output register. One item is taken every cycle unless the output
// stalls; while a result waits on a stalled output the parser holds, and the
// input register takes at most one more item before the input stalls.
module version_name_token_parser_top
  import vntp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic       held_valid;
  in_item_t   held;
  logic       go;
  parse_res_t res;

  assign go = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !go;

  vntp_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk (clk),
    .rst (rst),
    .en  (go),
    .item(held),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (go) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= res.hit;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.hit) begin
      result <= res.item;
    end
  end

endmodule

// ----- sim/tb_version_name_token_parser_top.sv -----
// self-checking testbench for the version name token parser
`timescale 1ns / 1ps

module tb_version_name_token_parser_top;
  import vntp_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam longint LIMIT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1000;
  localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS_DEF) - 1;
  localparam longint unsigned OFFSET_MAX = (64'd1 << OFFSET_BITS) - 1;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  in_item_t  item;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  logic      hold_off = 1'b0;
  logic [6:0] rx_cnt = '0;
  rx_mode_t  rx_mode = RX_FREE;

  out_item_t awaited_results[$];
  in_item_t  text_buf[$];
  dir_row_t  directed_rows[$];
  int        err_count = 0;
  int        items_taken = 0;
  int        burst_left = 1;

  logic [1:0]      ps_phase;
  logic [31:0]     ps_branch;
  logic [31:0]     ps_number;
  logic            ps_branch_seen;
  logic            ps_emitted;
  longint unsigned ps_pos;
  logic [2:0]      ps_fault;
  longint unsigned ps_fault_pos;

  version_name_token_parser_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void reset_parse_state();
    ps_phase = PH_START;
    ps_branch = '0;
    ps_number = '0;
    ps_branch_seen = 1'b0;
    ps_emitted = 1'b0;
    ps_pos = 0;
    ps_fault = ST_OK;
    ps_fault_pos = 0;
  endfunction

  function automatic void set_fault(logic [2:0] code, longint unsigned pos);
    ps_fault = code;
    ps_fault_pos = (code == ST_EXP_LETTER || code == ST_EXP_NUMBER) ? pos : 0;
  endfunction

  function automatic out_item_t shape_result(bit seg, bit done, logic [2:0] st,
                                             longint unsigned off);
    out_item_t r;
    r = '0;
    r.segment_valid = seg;
    r.branch_present = seg && ps_branch_seen;
    r.branch_ordinal = (seg && ps_branch_seen) ? ps_branch : '0;
    r.segment_number = seg ? ps_number : '0;
    r.done_res = done;
    r.status = st;
    r.error_offset = (off > OFFSET_MAX) ? '1 : off[OFFSET_BITS-1:0];
    return r;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic bit parse_version_char(input in_item_t it, output out_item_t res);
    logic [7:0]      c;
    logic [7:0]      lc;
    logic [35:0]     nxt;
    logic [2:0]      st;
    longint unsigned off;
    bit              seg;
    bit              got;
    c = it.character;
    lc = c | CASE_BIT;
    got = 1'b0;
    res = '0;
    if (it.has_char && ps_fault == ST_OK) begin
      if (is_alpha(c)) begin
        if (ps_phase == PH_LETTERS) begin
          ps_branch = ps_branch * 32'd26 + 32'(lc - LETTER_BIAS);
        end else if (ps_phase == PH_DIGITS && ps_number == '0) begin
          set_fault(ST_ZERO_SEG, 0);
        end else begin
          if (ps_phase == PH_DIGITS) begin
            res = shape_result(1'b1, 1'b0, ST_OK, 0);
            got = 1'b1;
            ps_emitted = 1'b1;
          end
          ps_phase = PH_LETTERS;
          ps_branch_seen = 1'b1;
          ps_branch = 32'(lc - LETTER_BIAS);
          ps_number = '0;
        end
      end else if (is_digit(c)) begin
        nxt = 36'(ps_number) * 36'd10 + 36'(c - CHAR_ZERO);
        if (nxt > 36'hFFFF_FFFF) begin
          set_fault(ST_TOO_LARGE, 0);
        end else begin
          ps_number = nxt[31:0];
          ps_phase = PH_DIGITS;
        end
      end else if (ps_phase == PH_DIGITS) begin
        set_fault(ps_number == '0 ? ST_ZERO_SEG : ST_EXP_LETTER, ps_pos);
      end else begin
        set_fault(ST_EXP_NUMBER, ps_pos);
      end
    end
    if (it.has_char && ps_pos < POS_MAX) ps_pos++;
    if (it.end_of_text) begin
      st = ps_fault;
      seg = 1'b0;
      off = ps_fault_pos;
      if (st == ST_OK) begin
        off = 0;
        if (ps_phase == PH_LETTERS) begin
          st = ST_EXP_NUMBER;
          off = ps_pos;
        end else if (ps_phase == PH_DIGITS && !(!ps_branch_seen && !ps_emitted &&
                     ps_number == '0 && ps_pos == 1)) begin
          if (ps_number == '0) st = ST_ZERO_SEG;
          else seg = 1'b1;
        end
      end
      res = shape_result(seg, 1'b1, st, off);
      got = 1'b1;
      reset_parse_state();
    end
    return got;
  endfunction

  function automatic in_item_t mk_item(logic [7:0] c, bit has, bit eot);
    in_item_t it;
    it.character = c;
    it.has_char = has;
    it.end_of_text = eot;
    return it;
  endfunction

  function automatic out_item_t done_of(logic [2:0] st, logic [15:0] off);
    out_item_t r;
    r = '0;
    r.done_res = 1'b1;
    r.status = st;
    r.error_offset = off;
    return r;
  endfunction

  function automatic out_item_t seg_of(bit bp, logic [31:0] ord, logic [31:0] num,
                                       bit done);
    out_item_t r;
    r = '0;
    r.segment_valid = 1'b1;
    r.branch_present = bp;
    r.branch_ordinal = ord;
    r.segment_number = num;
    r.done_res = done;
    r.status = ST_OK;
    return r;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = CHAR_LOWER_A + 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? (c & ~CASE_BIT) : c;
  endfunction

  function automatic logic [7:0] rand_punct();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_alpha(c) || is_digit(c));
    return c;
  endfunction

  task automatic add_row(logic [7:0] c, bit has, bit eot, bit typed = 1'b0,
                         out_item_t want = '0);
    dir_row_t row;
    row.stim = mk_item(c, has, eot);
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic note_error(string what, out_item_t want, out_item_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%s: want seg=%0d br=%0d ord=%h num=%h done=%0d st=%0d off=%0d", what,
               want.segment_valid, want.branch_present, want.branch_ordinal,
               want.segment_number, want.done_res, want.status, want.error_offset);
      $display("  got seg=%0d br=%0d ord=%h num=%h done=%0d st=%0d off=%0d",
               got.segment_valid, got.branch_present, got.branch_ordinal,
               got.segment_number, got.done_res, got.status, got.error_offset);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      note_error("result with nothing awaited", '0, got);
      return;
    end
    want = awaited_results.pop_front();
    if (got.segment_valid !== want.segment_valid ||
        got.branch_present !== want.branch_present ||
        got.branch_ordinal !== want.branch_ordinal ||
        got.segment_number !== want.segment_number ||
        got.done_res !== want.done_res ||
        got.status !== want.status ||
        got.error_offset !== want.error_offset)
      note_error("result mismatch", want, got);
  endtask

  // drive one item, wait for it to be taken, then predict its result
  task automatic offer_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t r;
    bit        got;
    int        gap;
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    got = parse_version_char(it, r);
    if (typed) begin
      got = 1'b1;
      r = want;
    end
    if (got) awaited_results.insert(awaited_results.size(), r);
    if (it.has_char || it.end_of_text) items_taken++;
    burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic add_letters(int n);
    repeat (n) text_buf.insert(text_buf.size(), mk_item(rand_letter(), 1'b1, 1'b0));
  endtask

  task automatic add_number();
    string s;
    int    n;
    case ($urandom_range(0, 9))
      0: s = "4294967295";
      1: s = "0";
      2: begin
        n = 10;
        s = "";
      end
      default: begin
        n = $urandom_range(1, 5);
        s = "";
      end
    endcase
    if (s.len() != 0) begin
      foreach (s[i]) text_buf.insert(text_buf.size(), mk_item(s[i], 1'b1, 1'b0));
    end else begin
      text_buf.insert(text_buf.size(),
                      mk_item(8'(CHAR_ZERO + $urandom_range(1, 9)), 1'b1, 1'b0));
      repeat (n - 1)
        text_buf.insert(text_buf.size(),
                        mk_item(8'(CHAR_ZERO + $urandom_range(0, 9)), 1'b1, 1'b0));
    end
  endtask

  task automatic build_text();
    int       kind;
    int       nseg;
    in_item_t last;
    text_buf.delete();
    kind = $urandom_range(0, 19);
    if (kind == 1) begin
      text_buf.insert(text_buf.size(), mk_item(CHAR_ZERO, 1'b1, 1'b0));
    end else if (kind == 2) begin
      repeat ($urandom_range(1, 6))
        text_buf.insert(text_buf.size(),
                        mk_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                1'b0));
    end else if (kind > 2) begin
      nseg = $urandom_range(1, 4);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0 || $urandom_range(0, 1))
          add_letters($urandom_range(0, 7) == 0 ? $urandom_range(7, 9) : $urandom_range(1, 3));
        add_number();
      end
      case ($urandom_range(0, 7))
        0: text_buf.insert($urandom_range(0, text_buf.size() - 1),
                           mk_item(rand_punct(), 1'b1, 1'b0));
        1: add_letters($urandom_range(1, 2));
        default: ;
      endcase
      for (int i = text_buf.size(); i > 0; i--)
        if ($urandom_range(0, 11) == 0)
          text_buf.insert(i - 1, mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
    end
    if (text_buf.size() > 0 && text_buf[$].has_char && $urandom_range(0, 1)) begin
      last = text_buf.pop_back();
      last.end_of_text = 1'b1;
      text_buf.insert(text_buf.size(), last);
    end else begin
      text_buf.insert(text_buf.size(), mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end
  endtask

  always @(posedge clk) begin : rx_side
    logic stall_now;
    if (!rst && result_valid && !result_stall) check_result(result);
    rx_cnt <= rx_cnt + 1'b1;
    if (rx_cnt == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:  stall_now = 1'b0;
      RX_LIGHT: stall_now = $urandom_range(0, 3) == 0;
      RX_HEAVY: stall_now = $urandom_range(0, 3) != 0;
      default:  stall_now = rx_cnt[2];
    endcase
    result_stall <= hold_off || stall_now;
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    while (items_taken < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_version_name_token_parser_top: errors");
    $finish;
  end

  initial begin
    string digits;
    digits = "429496729";
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    reset_parse_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_row(8'h00, 1'b0, 1'b1, 1'b1, done_of(ST_OK, 16'd0));
    add_row("0", 1'b1, 1'b1, 1'b1, done_of(ST_OK, 16'd0));
    add_row("a", 1'b1, 1'b0);
    add_row("1", 1'b1, 1'b0);
    add_row("B", 1'b1, 1'b0, 1'b1, seg_of(1'b1, 32'd1, 32'd1, 1'b0));
    add_row("2", 1'b1, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, 1'b1, seg_of(1'b1, 32'd2, 32'd2, 1'b1));
    foreach (digits[i]) add_row(digits[i], 1'b1, 1'b0);
    add_row("5", 1'b1, 1'b1, 1'b1, seg_of(1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1));
    add_row("Z", 1'b1, 1'b0);
    add_row("z", 1'b1, 1'b1, 1'b1, done_of(ST_EXP_NUMBER, 16'd2));
    add_row("0", 1'b1, 1'b0);
    add_row("a", 1'b1, 1'b1, 1'b1, done_of(ST_ZERO_SEG, 16'd0));
    add_row("1", 1'b1, 1'b0);
    add_row("-", 1'b1, 1'b1, 1'b1, done_of(ST_EXP_LETTER, 16'd1));
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, done_of(ST_EXP_NUMBER, 16'd0));
    foreach (directed_rows[i])
      offer_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    items_taken = 0;
    while (items_taken < RANDOM_ITEMS) begin
      build_text();
      foreach (text_buf[i]) offer_item(text_buf[i]);
    end

    item_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("tb_version_name_token_parser_top: clean");
    else
      $display("tb_version_name_token_parser_top: errors");
    $finish;
  end

endmodule
